@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MTA_ASSERT_HOLD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must hold in the same cycle as its cause.
`define MTA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its cause.
`define MTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mta_pkg.sv @@
package mta_pkg;

    localparam int VTX_DEPTH = 1024;
    localparam int VTX_AW    = $clog2(VTX_DEPTH);
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int DVD_W     = PROD_W + FRAC_BITS;
    localparam int STEP_W    = $clog2(DVD_W);
    localparam int SUM_W     = 48;
    localparam int CNT_W     = 8;
    localparam int FQ_DEPTH  = 2;
    localparam int FQ_AW     = $clog2(FQ_DEPTH);
    localparam int OQ_DEPTH  = 2;
    localparam int OQ_AW     = $clog2(OQ_DEPTH);

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_FACE = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    typedef enum logic [1:0] {
        K_LOAD,
        K_FACE,
        K_READ
    } t_kind;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_kind             kind;
        logic [VTX_AW-1:0] vidx;
        t_coord            px;
        t_coord            py;
        t_coord            pz;
        t_coord            tu;
        t_coord            tv;
        logic [VTX_AW-1:0] fa;
        logic [VTX_AW-1:0] fb;
        logic [VTX_AW-1:0] fc;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    typedef struct packed {
        t_coord px;
        t_coord py;
        t_coord pz;
        t_coord tu;
        t_coord tv;
    } t_vertex;

    typedef struct packed {
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sz;
        logic [CNT_W-1:0]        cnt;
    } t_accum;

    typedef struct packed {
        logic [VTX_AW-1:0] idx;
        t_coord            tx;
        t_coord            ty;
        t_coord            tz;
        logic [CNT_W-1:0]  cnt;
    } t_result;

    localparam t_coord D_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord D_NEG = {1'b1, {(COORD_W-2){1'b0}}, 1'b1};
    localparam t_coord Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Difference of two coordinates, clamped to the symmetric 32-bit range.
    function automatic t_coord f_delta(input t_coord hi, input t_coord lo);
        logic [COORD_W:0] d;
        d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
        if (!d[COORD_W] && d[COORD_W-1]) begin
            return D_MAX;
        end else if (d[COORD_W] && (!d[COORD_W-1] || d[COORD_W-2:0] == '0)) begin
            return D_NEG;
        end
        return t_coord'(d[COORD_W-1:0]);
    endfunction

    function automatic logic signed [SUM_W-1:0] f_sum_add(input logic signed [SUM_W-1:0] s,
                                                          input t_coord t);
        logic [SUM_W:0] r;
        r = {s[SUM_W-1], s} + {{(SUM_W+1-COORD_W){t[COORD_W-1]}}, t};
        if (r[SUM_W] != r[SUM_W-1]) begin
            return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return r[SUM_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] f_cnt_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic [PROD_W-1:0] f_abs(input logic signed [PROD_W-1:0] x);
        return x[PROD_W-1] ? -x : x;
    endfunction

    function automatic logic [SUM_W-1:0] f_abs_sum(input logic signed [SUM_W-1:0] x);
        return x[SUM_W-1] ? -x : x;
    endfunction

endpackage

@@ rtl/core/mta_ram.sv @@
module mta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/mta_front.sv @@
module mta_front import mta_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [1:0]        i_req_type,
    input  logic [VTX_AW-1:0] i_vertex_index,
    input  t_coord            i_pos_x,
    input  t_coord            i_pos_y,
    input  t_coord            i_pos_z,
    input  t_coord            i_tex_u,
    input  t_coord            i_tex_v,
    input  logic [VTX_AW-1:0] i_face_first,
    input  logic [VTX_AW-1:0] i_face_second,
    input  logic [VTX_AW-1:0] i_face_third,
    output logic              o_full,
    output t_qhead            o_head,
    input  logic              i_take
);

    localparam int QC_W = FQ_AW + 1;

    t_item            r_q [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wp;
    logic [FQ_AW-1:0] r_rp;
    logic [QC_W-1:0]  r_cnt;
    t_item            w_item;
    logic             w_keep;
    logic             w_store;
    logic             w_take;

    always_comb begin
        w_item.vidx = i_vertex_index;
        w_item.px   = i_pos_x;
        w_item.py   = i_pos_y;
        w_item.pz   = i_pos_z;
        w_item.tu   = i_tex_u;
        w_item.tv   = i_tex_v;
        w_item.fa   = i_face_first;
        w_item.fb   = i_face_second;
        w_item.fc   = i_face_third;
        w_keep      = 1'b1;
        unique case (i_req_type)
            REQ_LOAD: w_item.kind = K_LOAD;
            REQ_FACE: w_item.kind = K_FACE;
            REQ_READ: w_item.kind = K_READ;
            default: begin
                w_item.kind = K_LOAD;
                w_keep      = 1'b0;
            end
        endcase
    end

    assign o_full       = (r_cnt == QC_W'(FQ_DEPTH));
    assign w_store      = i_push && !o_full && w_keep;
    assign w_take       = i_take && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_store) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_take) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({w_store, w_take})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

@@ rtl/core/mta_div.sv @@
module mta_div import mta_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dvd,
    input  logic [PROD_W-1:0] i_dvs,
    input  logic              i_neg,
    output logic              o_busy,
    output t_coord            o_quo
);

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [PROD_W-1:0] r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [PROD_W-1:0] r_dvs;
    logic              r_neg;
    logic              r_zero;
    logic [COORD_W:0]  r_quo;
    logic              r_ovf;
    logic [PROD_W:0]   w_shift;
    logic [PROD_W:0]   w_diff;
    logic              w_ge;
    logic              w_big;

    assign w_shift = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= STEP_W'(DVD_W - 1);
            r_rem  <= '0;
            r_dvd  <= i_dvd;
            r_dvs  <= i_dvs;
            r_neg  <= i_neg;
            r_zero <= (i_dvs == '0);
            r_quo  <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= w_ge ? w_diff[PROD_W-1:0] : w_shift[PROD_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[COORD_W-1:0], w_ge};
            r_ovf <= r_ovf | r_quo[COORD_W];
        end
    end

    assign w_big  = r_ovf | r_quo[COORD_W] | r_quo[COORD_W-1];
    assign o_busy = r_busy;

    always_comb begin
        if (r_zero) begin
            o_quo = '0;
        end else if (r_neg) begin
            o_quo = w_big ? Q_MIN : t_coord'(-r_quo[COORD_W-1:0]);
        end else begin
            o_quo = w_big ? D_MAX : t_coord'(r_quo[COORD_W-1:0]);
        end
    end

endmodule

@@ rtl/core/mta_back.sv @@
module mta_back import mta_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qhead  i_head,
    output logic    o_take,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_LOAD     = 16'h0002,
        S_VRD_A    = 16'h0004,
        S_VRD_B    = 16'h0008,
        S_VRD_C    = 16'h0010,
        S_VLAT     = 16'h0020,
        S_DELTA    = 16'h0040,
        S_MUL      = 16'h0080,
        S_DIV_GO   = 16'h0100,
        S_DIV_WAIT = 16'h0200,
        S_ACC_RD   = 16'h0400,
        S_ACC_WR   = 16'h0800,
        S_AVG_RD   = 16'h1000,
        S_AVG_GO   = 16'h2000,
        S_AVG_WAIT = 16'h4000,
        S_OUT      = 16'h8000
    } t_state;

    localparam int MUL_STEPS = 8;
    localparam int MS_W      = $clog2(MUL_STEPS) + 1;
    localparam int LANES     = 3;
    localparam int FACE_V    = 3;
    localparam int K_W       = $clog2(FACE_V);

    t_state                   r_state;
    t_state                   n_state;
    t_item                    r_item;
    t_vertex                  r_va;
    t_vertex                  r_vb;
    t_vertex                  r_vc;
    t_coord                   r_e1x, r_e1y, r_e1z;
    t_coord                   r_e2x, r_e2y, r_e2z;
    t_coord                   r_du1, r_dv1, r_du2, r_dv2;
    logic [MS_W-1:0]          r_step;
    logic                     r_pvalid;
    logic [MS_W-2:0]          r_pstep;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_first;
    logic signed [PROD_W-1:0] r_det, r_nx, r_ny, r_nz;
    logic [K_W-1:0]           r_k;
    logic [CNT_W-1:0]         r_cnt_out;

    t_coord                   w_ma, w_mb;
    logic [VTX_AW-1:0]        w_idx_k;
    logic [VTX_AW-1:0]        w_vaddr;
    logic [VTX_AW-1:0]        w_araddr;
    logic [VTX_AW-1:0]        w_awaddr;
    t_vertex                  w_vwdata;
    t_vertex                  w_vrow;
    t_accum                   w_awdata;
    t_accum                   w_arow;
    logic                     w_vwe;
    logic                     w_awe;
    logic                     w_face_go;
    logic                     w_avg_go;
    logic [PROD_W-1:0]        w_dvs;
    logic signed [PROD_W-1:0] w_num [LANES];
    logic signed [SUM_W-1:0]  w_sum [LANES];
    logic [DVD_W-1:0]         w_dvd [LANES];
    logic [LANES-1:0]         w_neg;
    logic [LANES-1:0]         w_busy;
    t_coord                   w_quo [LANES];

    mta_ram #(.WIDTH($bits(t_vertex)), .DEPTH(VTX_DEPTH)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (r_item.vidx),
        .i_wdata (w_vwdata),
        .i_raddr (w_vaddr),
        .o_rdata (w_vrow)
    );

    mta_ram #(.WIDTH($bits(t_accum)), .DEPTH(VTX_DEPTH)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_awe),
        .i_waddr (w_awaddr),
        .i_wdata (w_awdata),
        .i_raddr (w_araddr),
        .o_rdata (w_arow)
    );

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mta_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_face_go || w_avg_go),
            .i_dvd   (w_dvd[g]),
            .i_dvs   (w_dvs),
            .i_neg   (w_neg[g]),
            .o_busy  (w_busy[g]),
            .o_quo   (w_quo[g])
        );
    end

    always_comb begin
        unique case (r_k)
            K_W'(0): w_idx_k = r_item.fa;
            K_W'(1): w_idx_k = r_item.fb;
            default: w_idx_k = r_item.fc;
        endcase
        if (r_state == S_VRD_A) begin
            w_vaddr = r_item.fa;
        end else if (r_state == S_VRD_B) begin
            w_vaddr = r_item.fb;
        end else begin
            w_vaddr = r_item.fc;
        end
        w_araddr    = (r_state == S_AVG_RD) ? r_item.vidx : w_idx_k;
        w_vwe       = (r_state == S_LOAD);
        w_vwdata.px = r_item.px;
        w_vwdata.py = r_item.py;
        w_vwdata.pz = r_item.pz;
        w_vwdata.tu = r_item.tu;
        w_vwdata.tv = r_item.tv;
        w_awe       = (r_state == S_LOAD) || (r_state == S_ACC_WR);
        w_awaddr    = (r_state == S_LOAD) ? r_item.vidx : w_idx_k;
        if (r_state == S_LOAD) begin
            w_awdata = '0;
        end else begin
            w_awdata.sx  = f_sum_add(w_arow.sx, w_quo[0]);
            w_awdata.sy  = f_sum_add(w_arow.sy, w_quo[1]);
            w_awdata.sz  = f_sum_add(w_arow.sz, w_quo[2]);
            w_awdata.cnt = f_cnt_inc(w_arow.cnt);
        end
    end

    always_comb begin
        unique case (r_step[MS_W-2:0])
            3'd0: begin w_ma = r_du1; w_mb = r_dv2; end
            3'd1: begin w_ma = r_dv1; w_mb = r_du2; end
            3'd2: begin w_ma = r_dv2; w_mb = r_e1x; end
            3'd3: begin w_ma = r_dv1; w_mb = r_e2x; end
            3'd4: begin w_ma = r_dv2; w_mb = r_e1y; end
            3'd5: begin w_ma = r_dv1; w_mb = r_e2y; end
            3'd6: begin w_ma = r_dv2; w_mb = r_e1z; end
            default: begin w_ma = r_dv1; w_mb = r_e2z; end
        endcase
    end

    always_comb begin
        w_face_go = (r_state == S_DIV_GO);
        w_avg_go  = (r_state == S_AVG_GO);
        w_dvs     = w_face_go ? f_abs(r_det) : PROD_W'(w_arow.cnt);
        w_num[0]  = r_nx;
        w_num[1]  = r_ny;
        w_num[2]  = r_nz;
        w_sum[0]  = w_arow.sx;
        w_sum[1]  = w_arow.sy;
        w_sum[2]  = w_arow.sz;
        for (int j = 0; j < LANES; j++) begin
            if (w_face_go) begin
                w_dvd[j] = {f_abs(w_num[j]), {FRAC_BITS{1'b0}}};
                w_neg[j] = w_num[j][PROD_W-1] ^ r_det[PROD_W-1];
            end else begin
                w_dvd[j] = DVD_W'(f_abs_sum(w_sum[j]));
                w_neg[j] = w_sum[j][SUM_W-1];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_take  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_take = 1'b1;
                    unique case (i_head.item.kind)
                        K_LOAD:  n_state = S_LOAD;
                        K_FACE:  n_state = S_VRD_A;
                        K_READ:  n_state = S_AVG_RD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD:   n_state = S_IDLE;
            S_VRD_A:  n_state = S_VRD_B;
            S_VRD_B:  n_state = S_VRD_C;
            S_VRD_C:  n_state = S_VLAT;
            S_VLAT:   n_state = S_DELTA;
            S_DELTA:  n_state = S_MUL;
            S_MUL: begin
                if (r_step == MS_W'(MUL_STEPS)) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_busy == '0) begin
                    n_state = S_ACC_RD;
                end
            end
            S_ACC_RD: n_state = S_ACC_WR;
            S_ACC_WR: n_state = (r_k == K_W'(FACE_V - 1)) ? S_IDLE : S_ACC_RD;
            S_AVG_RD: n_state = S_AVG_GO;
            S_AVG_GO: n_state = S_AVG_WAIT;
            S_AVG_WAIT: begin
                if (w_busy == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_pvalid <= 1'b0;
            r_k      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DELTA) begin
                r_step   <= '0;
                r_pvalid <= 1'b0;
            end else if (r_state == S_MUL) begin
                r_step   <= r_step + 1'b1;
                r_pvalid <= !r_step[MS_W-1];
            end
            if (r_state == S_DIV_GO) begin
                r_k <= '0;
            end else if (r_state == S_ACC_WR) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= i_head.item;
        end
        if (r_state == S_VRD_B) begin
            r_va <= w_vrow;
        end
        if (r_state == S_VRD_C) begin
            r_vb <= w_vrow;
        end
        if (r_state == S_VLAT) begin
            r_vc <= w_vrow;
        end
        if (r_state == S_DELTA) begin
            r_e1x <= f_delta(r_vb.px, r_va.px);
            r_e1y <= f_delta(r_vb.py, r_va.py);
            r_e1z <= f_delta(r_vb.pz, r_va.pz);
            r_e2x <= f_delta(r_vc.px, r_va.px);
            r_e2y <= f_delta(r_vc.py, r_va.py);
            r_e2z <= f_delta(r_vc.pz, r_va.pz);
            r_du1 <= f_delta(r_vb.tu, r_va.tu);
            r_dv1 <= f_delta(r_vb.tv, r_va.tv);
            r_du2 <= f_delta(r_vc.tu, r_va.tu);
            r_dv2 <= f_delta(r_vc.tv, r_va.tv);
        end
        if (r_state == S_MUL) begin
            r_prod  <= w_ma * w_mb;
            r_pstep <= r_step[MS_W-2:0];
            if (r_pvalid) begin
                if (!r_pstep[0]) begin
                    r_first <= r_prod;
                end else begin
                    unique case (r_pstep[MS_W-2:1])
                        2'd0:    r_det <= r_first - r_prod;
                        2'd1:    r_nx  <= r_first - r_prod;
                        2'd2:    r_ny  <= r_first - r_prod;
                        default: r_nz  <= r_first - r_prod;
                    endcase
                end
            end
        end
        if (w_avg_go) begin
            r_cnt_out <= w_arow.cnt;
        end
    end

    assign o_res_valid = (r_state == S_OUT);
    assign o_res.idx   = r_item.vidx;
    assign o_res.tx    = w_quo[0];
    assign o_res.ty    = w_quo[1];
    assign o_res.tz    = w_quo[2];
    assign o_res.cnt   = r_cnt_out;

endmodule

@@ rtl/core/mesh_tangent_accumulator.sv @@
// Channel   Dir  Handshake    Beat contents
// request   in   push / full  i_req_type, i_vertex_index, i_pos_x/y/z, i_tex_u/v, i_face_*
// result    out  empty / pop  o_read_index, o_tangent_x/y/z, o_face_count
//
// Faces and reads both run the 80-step restoring dividers, which retire one quotient
// bit per cycle; the three tangent lanes divide side by side.
// Reset clears the queues and the sequencer; the vertex and sum stores are not cleared.
// A two-entry request queue and a two-entry result queue let each side stall alone.
`include "assert_macros.svh"
module mesh_tangent_accumulator import mta_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_req_type,
    input  logic [VTX_AW-1:0] i_vertex_index,
    input  t_coord            i_pos_x,
    input  t_coord            i_pos_y,
    input  t_coord            i_pos_z,
    input  t_coord            i_tex_u,
    input  t_coord            i_tex_v,
    input  logic [VTX_AW-1:0] i_face_first,
    input  logic [VTX_AW-1:0] i_face_second,
    input  logic [VTX_AW-1:0] i_face_third,
    output logic              empty,
    input  logic              pop,
    output logic [VTX_AW-1:0] o_read_index,
    output t_coord            o_tangent_x,
    output t_coord            o_tangent_y,
    output t_coord            o_tangent_z,
    output logic [CNT_W-1:0]  o_face_count
);

    localparam int OC_W = OQ_AW + 1;

    t_qhead           w_head;
    logic             w_take;
    logic             w_res_valid;
    logic             w_res_ready;
    logic             w_res_push;
    logic             w_pop;
    t_result          w_res;
    t_result          r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_owp;
    logic [OQ_AW-1:0] r_orp;
    logic [OC_W-1:0]  r_ocnt;
    t_result          w_ohead;

    mta_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_req_type     (i_req_type),
        .i_vertex_index (i_vertex_index),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_tex_u        (i_tex_u),
        .i_tex_v        (i_tex_v),
        .i_face_first   (i_face_first),
        .i_face_second  (i_face_second),
        .i_face_third   (i_face_third),
        .o_full         (full),
        .o_head         (w_head),
        .i_take         (w_take)
    );

    mta_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    assign w_res_ready = (r_ocnt != OC_W'(OQ_DEPTH));
    assign w_res_push  = w_res_valid && w_res_ready;
    assign empty       = (r_ocnt == '0);
    assign w_pop       = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (w_res_push) begin
                r_owp <= r_owp + 1'b1;
            end
            if (w_pop) begin
                r_orp <= r_orp + 1'b1;
            end
            unique case ({w_res_push, w_pop})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_oq[r_owp] <= w_res;
        end
    end

    assign w_ohead      = r_oq[r_orp];
    assign o_read_index = w_ohead.idx;
    assign o_tangent_x  = w_ohead.tx;
    assign o_tangent_y  = w_ohead.ty;
    assign o_tangent_z  = w_ohead.tz;
    assign o_face_count = w_ohead.cnt;

    `MTA_ASSERT_IMPLY(a_take_has_head, i_clk, i_rst_n, w_take, w_head.valid, "take from empty queue")
    `MTA_ASSERT_NEXT(a_res_held, i_clk, i_rst_n, i_rst_n && w_res_valid && !w_res_ready, w_res_valid, "result dropped while queue full")
    `MTA_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, i_rst_n && w_pop && !w_res_push, r_ocnt == $past(r_ocnt) - 1'b1, "result count did not fall on pop")
    `MTA_ASSERT_HOLD(a_ocnt_range, i_clk, i_rst_n, r_ocnt <= OC_W'(OQ_DEPTH), "result queue overfilled")

endmodule
